FILE: src/token_bloom_filter_builder_top_assert.svh
// ---------------------------------------------------------------------------
// Token Bloom filter builder - assertion macros
// Concurrent property wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef TOKEN_BLOOM_FILTER_BUILDER_TOP_ASSERT_SVH
`define TOKEN_BLOOM_FILTER_BUILDER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define TBF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tbf: implication check failed");

`define TBF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tbf: next-cycle check failed");

`else

`define TBF_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define TBF_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/tbf_pkg.sv
// ---------------------------------------------------------------------------
// tbf_pkg
// Shared types, constants and helpers of the token Bloom filter builder.
// ---------------------------------------------------------------------------
package tbf_pkg;

	localparam int IDX_W      = 13;
	localparam int WORD_IDX_W = 7;
	localparam int BIT_POS_W  = 6;
	localparam int SIZE_W     = 4;

	localparam logic [SIZE_W-1:0] SIZE_MIN   = 4'd6;
	localparam logic [SIZE_W-1:0] SIZE_MAX   = 4'd13;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd13;

	localparam logic [31:0] DJB_SEED  = 32'd5381;
	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [31:0] SDBM_SEED = 32'd0;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef struct packed {
		logic             need;
		logic [IDX_W-1:0] idx0;
		logic [IDX_W-1:0] idx1;
		logic [IDX_W-1:0] idx2;
	} close_job_t;

	typedef struct packed {
		logic                  vld;
		logic                  is_read;
		logic [WORD_IDX_W-1:0] word;
		logic [BIT_POS_W-1:0]  bit_pos;
	} mem_op_t;

	typedef struct packed {
		logic                  vld;
		logic [WORD_IDX_W-1:0] word;
		logic [63:0]           data;
	} rd_res_t;

	typedef struct packed {
		logic mark_s1;
		logic read_s1;
	} store_stat_t;

	function automatic logic is_split_byte(input logic [7:0] c);
		is_split_byte = (c == 8'h20) || (c == 8'h22) || (c == 8'h3A) || (c == 8'h0A) ||
		                (c == 8'h0D) || (c == 8'h09) || (c == 8'h2C) || (c == 8'h7B) ||
		                (c == 8'h7D) || (c == 8'h5B) || (c == 8'h5D);
	endfunction

endpackage

FILE: src/token_bloom_filter_builder_top.sv
// ---------------------------------------------------------------------------
// token_bloom_filter_builder_top
// Splits a byte stream into tokens and sets three hash-indexed bits per
// token in a Bloom filter; reads return one 64-bit filter word.
// ---------------------------------------------------------------------------
//  channel | signals                                         | direction
//  in      | in_valid in_ready kind data_byte chunk_end      | sink
//          | word_index                                      |
//  out     | out_valid out_ready filter_word word_index_out  | source
//  cfg     | cfg_valid cfg_ready cfg_data (size_log2)        | sink
//
//  Data bytes: one per cycle unless in_ready stalls. A byte that ends a token
//  queues three bit read-modify-writes on the single memory port, issued one
//  per cycle; the next token end waits until the last of them issues.
//  Read: waits for queued bit sets, then goes through the store read stage and
//  the output buffer; reads can overlap while the buffer has room. Clear: valid
//  bits only. Reset: async, no memory sweep. Output has a two-beat buffer.
// ---------------------------------------------------------------------------
`include "token_bloom_filter_builder_top_assert.svh"

module token_bloom_filter_builder_top #(
	parameter int FILTER_BITS = 8192
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         kind,
	input  logic [7:0]                         data_byte,
	input  logic                               chunk_end,
	input  logic [tbf_pkg::WORD_IDX_W-1:0]     word_index,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [63:0]                        filter_word,
	output logic [tbf_pkg::WORD_IDX_W-1:0]     word_index_out,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tbf_pkg::SIZE_W-1:0]         cfg_data
);

	logic [tbf_pkg::SIZE_W-1:0] size_log2_q;

	tbf_pkg::close_job_t   job;
	tbf_pkg::mem_op_t      op;
	tbf_pkg::rd_res_t      res;
	tbf_pkg::store_stat_t  st;

	logic [tbf_pkg::IDX_W-1:0] mk_q [3];
	logic [1:0]                mk_cnt_q;

	logic [63:0]                    fifo_data_q [2];
	logic [tbf_pkg::WORD_IDX_W-1:0] fifo_word_q [2];
	logic                           wr_ptr_q, rd_ptr_q;
	logic [1:0]                     out_cnt_q;

	logic accept, byte_take, read_take, clear_take, load;
	logic mark_free, read_room, push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log2_q <= tbf_pkg::SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			size_log2_q <= cfg_data;
		end
	end

	assign mark_free = (mk_cnt_q <= 2'd1);
	assign read_room = (out_cnt_q == 2'd0) || ((out_cnt_q == 2'd1) && !st.read_s1);

	always_comb begin
		unique case (kind)
			tbf_pkg::KIND_BYTE:  in_ready = !job.need || mark_free;
			tbf_pkg::KIND_READ:  in_ready = (mk_cnt_q == 2'd0) && read_room;
			tbf_pkg::KIND_CLEAR: in_ready = (mk_cnt_q == 2'd0) && !st.mark_s1;
			tbf_pkg::KIND_NONE:  in_ready = 1'b1;
			default:             in_ready = 1'b1;
		endcase
	end

	assign accept     = in_valid && in_ready;
	assign byte_take  = accept && (kind == tbf_pkg::KIND_BYTE);
	assign read_take  = accept && (kind == tbf_pkg::KIND_READ);
	assign clear_take = accept && (kind == tbf_pkg::KIND_CLEAR);
	assign load       = byte_take && job.need;

	tbf_hash #(
		.FILTER_BITS (FILTER_BITS)
	) u_hash (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_take  (byte_take),
		.clear_take (clear_take),
		.data_byte  (data_byte),
		.chunk_end  (chunk_end),
		.size_log2  (size_log2_q),
		.job        (job)
	);

	// pending bit sets, oldest at slot 0
	always_ff @(posedge clk) begin
		if (load) begin
			mk_q[0] <= job.idx0;
			mk_q[1] <= job.idx1;
			mk_q[2] <= job.idx2;
		end else if (mk_cnt_q != 2'd0) begin
			mk_q[0] <= mk_q[1];
			mk_q[1] <= mk_q[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mk_cnt_q <= 2'd0;
		end else if (load) begin
			mk_cnt_q <= 2'd3;
		end else if (mk_cnt_q != 2'd0) begin
			mk_cnt_q <= mk_cnt_q - 2'd1;
		end
	end

	always_comb begin
		if (mk_cnt_q != 2'd0) begin
			op.vld     = 1'b1;
			op.is_read = 1'b0;
			op.word    = mk_q[0][tbf_pkg::IDX_W-1:tbf_pkg::BIT_POS_W];
			op.bit_pos = mk_q[0][tbf_pkg::BIT_POS_W-1:0];
		end else begin
			op.vld     = read_take;
			op.is_read = read_take;
			op.word    = word_index;
			op.bit_pos = '0;
		end
	end

	tbf_store #(
		.FILTER_BITS (FILTER_BITS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.clear  (clear_take),
		.res    (res),
		.stat   (st)
	);

	assign push = res.vld;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_data_q[wr_ptr_q] <= res.data;
			fifo_word_q[wr_ptr_q] <= res.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q  <= 1'b0;
			rd_ptr_q  <= 1'b0;
			out_cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				out_cnt_q <= out_cnt_q + 2'd1;
			end else if (pop && !push) begin
				out_cnt_q <= out_cnt_q - 2'd1;
			end
		end
	end

	assign out_valid      = (out_cnt_q != 2'd0);
	assign filter_word    = fifo_data_q[rd_ptr_q];
	assign word_index_out = fifo_word_q[rd_ptr_q];

	`TBF_ASSERT_IMP(a_clear_quiet, clk, arst_n, clear_take, (mk_cnt_q == 2'd0) && !st.mark_s1)
	`TBF_ASSERT_IMP(a_push_room, clk, arst_n, push, out_cnt_q != 2'd2)
	`TBF_ASSERT_NXT(a_job_loaded, clk, arst_n, load, mk_cnt_q == 2'd3)

endmodule

FILE: src/tbf_hash.sv
// ---------------------------------------------------------------------------
// tbf_hash
// Token splitter with running djb2, FNV-1a and sdbm hashes; emits the three
// masked filter bit indices when a byte closes a token.
// ---------------------------------------------------------------------------
module tbf_hash #(
	parameter int FILTER_BITS = 8192
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             byte_take,
	input  logic                             clear_take,
	input  logic [7:0]                       data_byte,
	input  logic                             chunk_end,
	input  logic [tbf_pkg::SIZE_W-1:0]       size_log2,
	output tbf_pkg::close_job_t              job
);

	localparam logic [tbf_pkg::IDX_W-1:0] FMASK = tbf_pkg::IDX_W'(FILTER_BITS - 1);

	logic [31:0] djb_q, fnv_q, sdbm_q;
	logic        in_token_q;

	logic [31:0] c32, fnv_x;
	logic [31:0] djb_n, fnv_n, sdbm_n;
	logic [31:0] djb_m, fnv_m, sdbm_m;
	logic        delim;
	logic [tbf_pkg::SIZE_W-1:0] lg;
	logic [tbf_pkg::IDX_W-1:0]  mask;

	assign c32    = {24'd0, data_byte};
	assign djb_n  = (djb_q << 5) + djb_q + c32;
	assign fnv_x  = fnv_q ^ c32;
	assign fnv_n  = fnv_x * tbf_pkg::FNV_PRIME;
	assign sdbm_n = c32 + (sdbm_q << 6) + (sdbm_q << 16) - sdbm_q;
	assign delim  = tbf_pkg::is_split_byte(data_byte);

	always_comb begin
		if (size_log2 < tbf_pkg::SIZE_MIN) begin
			lg = tbf_pkg::SIZE_MIN;
		end else if (size_log2 > tbf_pkg::SIZE_MAX) begin
			lg = tbf_pkg::SIZE_MAX;
		end else begin
			lg = size_log2;
		end
	end

	assign mask = ~({tbf_pkg::IDX_W{1'b1}} << lg) & FMASK;

	// delimiter closes the open token with the current hashes; otherwise
	// chunk end closes it with the hashes that include this byte
	assign djb_m  = delim ? djb_q  : djb_n;
	assign fnv_m  = delim ? fnv_q  : fnv_n;
	assign sdbm_m = delim ? sdbm_q : sdbm_n;

	assign job.need = delim ? in_token_q : chunk_end;
	assign job.idx0 = djb_m[tbf_pkg::IDX_W-1:0] & mask;
	assign job.idx1 = fnv_m[tbf_pkg::IDX_W-1:0] & mask;
	assign job.idx2 = sdbm_m[tbf_pkg::IDX_W-1:0] & mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			djb_q      <= tbf_pkg::DJB_SEED;
			fnv_q      <= tbf_pkg::FNV_BASIS;
			sdbm_q     <= tbf_pkg::SDBM_SEED;
			in_token_q <= 1'b0;
		end else if (clear_take || (byte_take && (delim || chunk_end))) begin
			djb_q      <= tbf_pkg::DJB_SEED;
			fnv_q      <= tbf_pkg::FNV_BASIS;
			sdbm_q     <= tbf_pkg::SDBM_SEED;
			in_token_q <= 1'b0;
		end else if (byte_take) begin
			djb_q      <= djb_n;
			fnv_q      <= fnv_n;
			sdbm_q     <= sdbm_n;
			in_token_q <= 1'b1;
		end
	end

endmodule

FILE: src/tbf_store.sv
// ---------------------------------------------------------------------------
// tbf_store
// Filter word memory with per-word valid bits, registered read,
// bit-set read-modify-write and forwarding of the previous write.
// ---------------------------------------------------------------------------
module tbf_store #(
	parameter int FILTER_BITS = 8192
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tbf_pkg::mem_op_t      op,
	input  logic                  clear,
	output tbf_pkg::rd_res_t      res,
	output tbf_pkg::store_stat_t  stat
);

	localparam int NUM_WORDS = FILTER_BITS / 64;
	localparam int DEPTH     = (NUM_WORDS < 128) ? NUM_WORDS : 128;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [63:0] mem [DEPTH];
	logic [DEPTH-1:0] vbits_q;

	logic                             vld_s1, is_read_s1, oob_s1, hitv_s1;
	logic [tbf_pkg::WORD_IDX_W-1:0]   word_s1;
	logic [tbf_pkg::BIT_POS_W-1:0]    bit_s1;
	logic [63:0]                      rd_s1;

	logic                             wq_vld_q;
	logic [AW-1:0]                    wq_addr_q;
	logic [63:0]                      wq_data_q;

	logic [AW-1:0] addr, addr_s1;
	logic          oob;
	logic [63:0]   cur, wr_data;
	logic          wr_en;

	assign addr    = op.word[AW-1:0];
	assign oob     = {25'd0, op.word} >= 32'(NUM_WORDS);
	assign addr_s1 = word_s1[AW-1:0];

	assign cur     = (wq_vld_q && (wq_addr_q == addr_s1)) ? wq_data_q :
	                 (hitv_s1 ? rd_s1 : 64'd0);
	assign wr_en   = vld_s1 && !is_read_s1 && !oob_s1;
	assign wr_data = cur | (64'd1 << bit_s1);

	assign res.vld  = vld_s1 && is_read_s1;
	assign res.word = word_s1;
	assign res.data = oob_s1 ? 64'd0 : cur;

	assign stat.mark_s1 = vld_s1 && !is_read_s1;
	assign stat.read_s1 = vld_s1 && is_read_s1;

	always_ff @(posedge clk) begin
		if (op.vld) begin
			rd_s1 <= mem[addr];
		end
		if (wr_en) begin
			mem[addr_s1] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		word_s1   <= op.word;
		bit_s1    <= op.bit_pos;
		oob_s1    <= oob;
		hitv_s1   <= vbits_q[addr];
		wq_addr_q <= addr_s1;
		wq_data_q <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			is_read_s1 <= 1'b0;
			wq_vld_q   <= 1'b0;
			vbits_q    <= '0;
		end else begin
			vld_s1     <= op.vld;
			is_read_s1 <= op.is_read;
			wq_vld_q   <= wr_en && !clear;
			if (clear) begin
				vbits_q <= '0;
			end else if (wr_en) begin
				vbits_q[addr_s1] <= 1'b1;
			end
		end
	end

endmodule

FILE: tb/sv/token_bloom_filter_builder_top_test.sv
// ---------------------------------------------------------------------------
// token_bloom_filter_builder_top_test
// Feeds text bytes, filter reads, clears and unused kinds through the valid/
// ready input channel, predicts the filter contents and checks every word
// read back. Random idle bursts on both channels, a long output hold-off,
// and filter size settings across the whole range.
// ---------------------------------------------------------------------------
module token_bloom_filter_builder_top_test;

	localparam int FILTER_BITS = 8192;
	localparam int FILTER_WORDS = FILTER_BITS / 64;
	localparam logic [31:0] DJB_INIT = 32'd5381;
	localparam logic [31:0] FNV_INIT = 32'd2166136261;
	localparam logic [31:0] FNV_MUL = 32'd16777619;
	localparam int LONG_HOLD = 400;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		tbf_pkg::kind_t op;
		logic [7:0]     ch;
		bit             last;
		logic [6:0]     widx;
	} text_item_t;

	typedef struct {
		logic [63:0] bits;
		logic [6:0]  widx;
	} word_read_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	tbf_pkg::kind_t kind = tbf_pkg::KIND_BYTE;
	logic [7:0] data_byte = 8'd0;
	logic chunk_end = 1'b0;
	logic [tbf_pkg::WORD_IDX_W-1:0] word_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [63:0] filter_word;
	logic [tbf_pkg::WORD_IDX_W-1:0] word_index_out;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [tbf_pkg::SIZE_W-1:0] cfg_data = '0;

	text_item_t pending_items[$];
	word_read_t expected_words[$];

	logic [63:0] bloom_words [FILTER_WORDS];
	logic [31:0] djb_h = DJB_INIT;
	logic [31:0] fnv_h = FNV_INIT;
	logic [31:0] sdbm_h = 32'd0;
	bit token_open = 1'b0;
	logic [3:0] size_now = 4'd13;

	logic [7:0] separators [11] = '{8'h20, 8'h22, 8'h3A, 8'h0A, 8'h0D, 8'h09,
		8'h2C, 8'h7B, 8'h7D, 8'h5B, 8'h5D};

	bit in_fire = 1'b0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	int dead_cycles = 0;
	int cfg_beats = 0;
	int mismatches = 0;

	token_bloom_filter_builder_top #(
		.FILTER_BITS(FILTER_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.data_byte(data_byte),
		.chunk_end(chunk_end),
		.word_index(word_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.filter_word(filter_word),
		.word_index_out(word_index_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit is_separator(input logic [7:0] c);
		for (int i = 0; i < 11; i++)
			if (separators[i] == c)
				return 1'b1;
		return 1'b0;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH: %s", msg);
		mismatches++;
	endtask

	task automatic set_hash_bit(input logic [31:0] h);
		int lg;
		int pos;
		lg = (size_now < 4'd6) ? 6 : (size_now > 4'd13) ? 13 : int'(size_now);
		pos = int'(h & ((32'd1 << lg) - 32'd1) & (FILTER_BITS - 1));
		if ((pos >> 6) < FILTER_WORDS)
			bloom_words[pos >> 6][pos & 63] = 1'b1;
	endtask

	task automatic restart_token();
		djb_h = DJB_INIT;
		fnv_h = FNV_INIT;
		sdbm_h = 32'd0;
		token_open = 1'b0;
	endtask

	task automatic close_token();
		if (token_open) begin
			set_hash_bit(djb_h);
			set_hash_bit(fnv_h);
			set_hash_bit(sdbm_h);
		end
		restart_token();
	endtask

	task automatic bloom_step(input text_item_t it);
		word_read_t w;
		logic [31:0] c;
		c = {24'd0, it.ch};
		case (it.op)
			tbf_pkg::KIND_BYTE: begin
				if (is_separator(it.ch)) begin
					close_token();
				end else begin
					djb_h = (djb_h << 5) + djb_h + c;
					fnv_h = (fnv_h ^ c) * FNV_MUL;
					sdbm_h = c + (sdbm_h << 6) + (sdbm_h << 16) - sdbm_h;
					token_open = 1'b1;
				end
				if (it.last)
					close_token();
			end
			tbf_pkg::KIND_READ: begin
				w.bits = (it.widx < FILTER_WORDS) ? bloom_words[it.widx] : 64'd0;
				w.widx = it.widx;
				expected_words.push_back(w);
			end
			tbf_pkg::KIND_CLEAR: begin
				for (int i = 0; i < FILTER_WORDS; i++)
					bloom_words[i] = 64'd0;
				restart_token();
			end
			default: begin
			end
		endcase
	endtask

	// sampling and prediction
	always @(posedge clk) begin : watch_ports
		word_read_t want;
		text_item_t seen;
		in_fire = in_valid && in_ready;
		if (out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				flag_mismatch($sformatf("unexpected beat word %0d data %h",
					word_index_out, filter_word));
			end else begin
				want = expected_words.pop_front();
				if (filter_word !== want.bits)
					flag_mismatch($sformatf("word %0d: got %h want %h",
						want.widx, filter_word, want.bits));
				if (word_index_out !== want.widx)
					flag_mismatch($sformatf("word index: got %0d want %0d",
						word_index_out, want.widx));
			end
		end
		if (in_fire) begin
			seen.op = kind;
			seen.ch = data_byte;
			seen.last = chunk_end;
			seen.widx = word_index;
			bloom_step(seen);
		end
		if (cfg_valid && cfg_ready) begin
			size_now = cfg_data;
			cfg_beats++;
		end
	end

	always @(negedge clk) begin : feed_items
		logic offer;
		offer = 1'b0;
		if (in_fire)
			void'(pending_items.pop_front());
		if (in_valid && !in_fire) begin
			offer = 1'b1;
		end else begin
			if (in_fire && !calm && $urandom_range(0, 7) == 0)
				send_gap = $urandom_range(1, 16);
			if (send_gap > 0)
				send_gap--;
			else if (arst_n && pending_items.size() > 0)
				offer = 1'b1;
		end
		if (offer) begin
			kind <= pending_items[0].op;
			data_byte <= pending_items[0].ch;
			chunk_end <= pending_items[0].last;
			word_index <= pending_items[0].widx;
		end
		in_valid <= offer;
	end

	always @(negedge clk) begin : drain_words
		logic take;
		take = 1'b1;
		if (hold_left > 0) begin
			hold_left--;
			take = 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD - 1;
			take = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			take = 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 16);
		end
		out_ready <= take;
	end

	always @(posedge clk) begin : stall_watch
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			dead_cycles = 0;
		else
			dead_cycles++;
		if (dead_cycles == STALL_LIMIT) begin
			$display("token_bloom_filter_builder_top_test: done, errors");
			$finish;
		end
	end

	task automatic queue_item(input tbf_pkg::kind_t op, input logic [7:0] ch,
		input bit last, input logic [6:0] widx);
		text_item_t it;
		it.op = op;
		it.ch = ch;
		it.last = last;
		it.widx = widx;
		pending_items.push_back(it);
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || expected_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_size(input logic [3:0] v);
		int seen;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		seen = cfg_beats;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		wait (cfg_beats != seen);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly well-formed tokens, with reads, noise, clears and unused kinds
	task automatic fill_phase(input int n, input int lg);
		int count;
		int r;
		int len;
		logic [7:0] c;
		bit end_on_byte;
		count = 0;
		while (count < n) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				len = $urandom_range(1, 8);
				end_on_byte = ($urandom_range(0, 9) < 3);
				for (int i = 0; i < len; i++) begin
					do c = 8'($urandom_range(0, 255)); while (is_separator(c));
					queue_item(tbf_pkg::KIND_BYTE, c, end_on_byte && i == len - 1,
						7'($urandom));
				end
				count += len;
				if (!end_on_byte) begin
					len = $urandom_range(1, 2);
					for (int i = 0; i < len; i++)
						queue_item(tbf_pkg::KIND_BYTE,
							separators[4'($urandom_range(0, 10))],
							i == len - 1 && $urandom_range(0, 4) == 0, 7'($urandom));
					count += len;
				end
			end else if (r < 82) begin
				if ($urandom_range(0, 9) < 7)
					queue_item(tbf_pkg::KIND_READ, 8'($urandom), 1'($urandom_range(0, 1)),
						7'($urandom_range(0, (1 << (lg - 6)) - 1)));
				else
					queue_item(tbf_pkg::KIND_READ, 8'($urandom), 1'($urandom_range(0, 1)),
						7'($urandom_range(0, 127)));
				count++;
			end else if (r < 96) begin
				queue_item(tbf_pkg::KIND_BYTE, 8'($urandom_range(0, 255)),
					$urandom_range(0, 3) == 0, 7'($urandom));
				count++;
			end else if (r < 98) begin
				queue_item(tbf_pkg::KIND_CLEAR, 8'($urandom), 1'($urandom_range(0, 1)),
					7'($urandom));
				count++;
			end else begin
				queue_item(tbf_pkg::KIND_NONE, 8'($urandom), 1'($urandom_range(0, 1)),
					7'($urandom));
			end
		end
	endtask

	initial begin : run_test
		logic [3:0] phase_sizes [8];
		int lg;
		phase_sizes = '{4'd6, 4'd13, 4'd0, 4'd15, 4'd9, 4'd7, 4'd12, 4'd10};
		for (int i = 0; i < FILTER_WORDS; i++)
			bloom_words[i] = 64'd0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		queue_item(tbf_pkg::KIND_READ, 8'h00, 1'b0, 7'd0);
		queue_item(tbf_pkg::KIND_READ, 8'hFF, 1'b1, 7'd127);
		queue_item(tbf_pkg::KIND_BYTE, 8'h61, 1'b0, 7'd0);
		queue_item(tbf_pkg::KIND_BYTE, 8'h62, 1'b1, 7'd0);
		queue_item(tbf_pkg::KIND_BYTE, 8'h20, 1'b0, 7'd0);
		queue_item(tbf_pkg::KIND_BYTE, 8'h2C, 1'b0, 7'd0);
		queue_item(tbf_pkg::KIND_BYTE, 8'h00, 1'b0, 7'd0);
		queue_item(tbf_pkg::KIND_BYTE, 8'hFF, 1'b0, 7'd127);
		queue_item(tbf_pkg::KIND_BYTE, 8'h3A, 1'b0, 7'd0);
		queue_item(tbf_pkg::KIND_BYTE, 8'h71, 1'b0, 7'd0);
		queue_item(tbf_pkg::KIND_BYTE, 8'h7D, 1'b1, 7'd0);
		queue_item(tbf_pkg::KIND_BYTE, 8'h22, 1'b1, 7'd0);
		queue_item(tbf_pkg::KIND_NONE, 8'h7A, 1'b1, 7'd127);
		for (int i = 0; i < 4; i++)
			queue_item(tbf_pkg::KIND_READ, 8'h00, 1'b0, 7'($urandom_range(0, 127)));
		queue_item(tbf_pkg::KIND_BYTE, 8'h7A, 1'b0, 7'd0);
		queue_item(tbf_pkg::KIND_CLEAR, 8'hFF, 1'b1, 7'd127);
		queue_item(tbf_pkg::KIND_READ, 8'h00, 1'b0, 7'd0);
		queue_item(tbf_pkg::KIND_BYTE, 8'h79, 1'b1, 7'd0);
		queue_item(tbf_pkg::KIND_READ, 8'h00, 1'b0, 7'd127);

		for (int p = 0; p < 8; p++) begin
			write_size(phase_sizes[p]);
			lg = (phase_sizes[p] < 4'd6) ? 6 : (phase_sizes[p] > 4'd13) ? 13 :
				int'(phase_sizes[p]);
			calm = (p == 7) || ($urandom_range(0, 3) == 0);
			if (p == 1) begin
				hold_req = 1'b1;
				for (int i = 0; i < 30; i++)
					queue_item(tbf_pkg::KIND_READ, 8'($urandom), 1'b0,
						7'($urandom_range(0, 127)));
			end
			fill_phase(170, lg);
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("token_bloom_filter_builder_top_test: done, clean");
		else
			$display("token_bloom_filter_builder_top_test: done, errors");
		$finish;
	end

endmodule
